### rtl/s128alu_pkg.sv
package s128alu_pkg;

	typedef enum logic [4:0] {
		OP_AND = 5'd0,
		OP_OR  = 5'd1,
		OP_XOR = 5'd2,
		OP_NOT = 5'd3,
		OP_SHL = 5'd4,
		OP_SAR = 5'd5,
		OP_ROL = 5'd6,
		OP_ROR = 5'd7,
		OP_ADD = 5'd8,
		OP_SUB = 5'd9,
		OP_NEG = 5'd10,
		OP_MUL = 5'd11,
		OP_DIV = 5'd12,
		OP_EQ  = 5'd13,
		OP_NE  = 5'd14,
		OP_LT  = 5'd15,
		OP_GT  = 5'd16,
		OP_LE  = 5'd17,
		OP_GE  = 5'd18
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_DIV0 = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ITER,
		S_FIX,
		S_OUT
	} fsm_t;

	localparam int unsigned OP_W = 5;
	localparam int unsigned HALF_W = 64;
	localparam int unsigned SH_W = 7;
	localparam int unsigned IN_BYTES_W = 272;
	localparam int unsigned OUT_BYTES_W = 136;

	typedef struct packed {
		logic start;
		logic is_mul;
		logic busy;
		logic done;
	} iter_ctl_t;

endpackage

### rtl/s128alu_iter.sv
module s128alu_iter
	import s128alu_pkg::*;
#(
	parameter int unsigned WIDTH = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               is_mul,
	input  logic [WIDTH-1:0]   x,
	input  logic [WIDTH-1:0]   y,
	output iter_ctl_t          ctl,
	output logic [WIDTH-1:0]   lo,
	output logic [WIDTH-1:0]   hi
);

	localparam int unsigned CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] acc_q, sh_q, y_q;
	logic [CW-1:0]    cnt_q;
	logic             mul_q, busy_q, done_q;
	logic [WIDTH:0]   sum;
	logic [WIDTH:0]   rem_sh;
	logic [WIDTH:0]   diff;

	// mul: acc is upper product, sh holds multiplier then lower product
	// div: acc is remainder, sh holds dividend then quotient
	always_comb begin
		sum = {1'b0, acc_q} + (sh_q[0] ? {1'b0, y_q} : '0);
		rem_sh = {acc_q, sh_q[WIDTH-1]};
		diff = rem_sh - {1'b0, y_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			mul_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(WIDTH);
				mul_q <= is_mul;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			sh_q <= x;
			y_q <= y;
		end else if (busy_q) begin
			if (mul_q) begin
				acc_q <= sum[WIDTH:1];
				sh_q <= {sum[0], sh_q[WIDTH-1:1]};
			end else if (!diff[WIDTH]) begin
				acc_q <= diff[WIDTH-1:0];
				sh_q <= {sh_q[WIDTH-2:0], 1'b1};
			end else begin
				acc_q <= rem_sh[WIDTH-1:0];
				sh_q <= {sh_q[WIDTH-2:0], 1'b0};
			end
		end
	end

	assign ctl = '{start: start, is_mul: mul_q, busy: busy_q, done: done_q};
	assign lo = sh_q;
	assign hi = acc_q;

`ifndef NO_ASSERTIONS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start) else $error("start while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("done held");
	a_done_after: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("done without work");
`endif

endmodule

### rtl/signed_128bit_alu_core.sv
// logic, shift, add and compare ops skip the iteration, result set in S_FIX
// mul and div iterate one operand bit per cycle, except div by zero or overflow
// throughput: one transfer at a time; the next is taken after the result leaves
// the iteration count is set by WIDTH, loaded into the counter in s128alu_iter
// reset: arst_n clears the sequencer and output valid, payload is not reset
module signed_128bit_alu_core
	import s128alu_pkg::*;
#(
	parameter int unsigned WIDTH = 128
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// op, a_high, a_low, b_high, b_low, shift_amount, zero pad
	input  logic [IN_BYTES_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// result_high, result_low, compare_true, status, zero pad
	output logic [OUT_BYTES_W-1:0] m_tdata
);

	localparam int unsigned CNT = 2 * HALF_W;

	fsm_t state_q, state_d;
	logic [OP_W-1:0]  op_q;
	logic [WIDTH-1:0] a_q, b_q;
	logic [SH_W-1:0]  sh_q;
	logic [WIDTH-1:0] res_q, res_d;
	logic             cmp_q, cmp_d;
	status_t          st_q, st_d;
	logic             sn_q;
	logic             first_q;

	logic [CNT-1:0]   a_in, b_in;
	logic [WIDTH-1:0] a_w, b_w, ma, mb, it_lo, it_hi, qn;
	logic             go_iter, start;
	iter_ctl_t        ictl;
	logic [WIDTH-1:0] min_v;

	assign a_in = {s_tdata[OP_W +: HALF_W], s_tdata[OP_W+HALF_W +: HALF_W]};
	assign b_in = {s_tdata[OP_W+2*HALF_W +: HALF_W], s_tdata[OP_W+3*HALF_W +: HALF_W]};
	assign a_w = a_in[WIDTH-1:0];
	assign b_w = b_in[WIDTH-1:0];
	assign min_v = {1'b1, {(WIDTH-1){1'b0}}};

	assign ma = a_q[WIDTH-1] ? -a_q : a_q;
	assign mb = b_q[WIDTH-1] ? -b_q : b_q;
	assign go_iter = (op_q == OP_MUL) || (op_q == OP_DIV && b_q != '0
		&& !(a_q == min_v && b_q == '1));
	assign start = first_q && go_iter;

	s128alu_iter #(.WIDTH(WIDTH)) u_iter (
		.clk(clk), .arst_n(arst_n), .start(start), .is_mul(op_q == OP_MUL),
		.x(ma), .y(mb), .ctl(ictl), .lo(it_lo), .hi(it_hi)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (s_tvalid) state_d = S_ITER;
			S_ITER: if (!go_iter || ictl.done) state_d = S_FIX;
			S_FIX:  state_d = S_OUT;
			S_OUT:  if (m_tready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	logic [WIDTH:0]   sum, dif;
	logic             lt;
	always_comb begin
		sum = {1'b0, a_q} + {1'b0, b_q};
		dif = {1'b0, a_q} - {1'b0, b_q};
		lt = (a_q[WIDTH-1] != b_q[WIDTH-1]) ? a_q[WIDTH-1] : dif[WIDTH];
		qn = sn_q ? -it_lo : it_lo;
		res_d = '0;
		cmp_d = 1'b0;
		st_d = ST_OK;
		unique case (op_q)
			OP_AND: res_d = a_q & b_q;
			OP_OR:  res_d = a_q | b_q;
			OP_XOR: res_d = a_q ^ b_q;
			OP_NOT: res_d = ~a_q;
			OP_SHL: res_d = a_q << sh_q;
			OP_SAR: res_d = ($signed(a_q) >>> ((sh_q >= WIDTH) ? SH_W'(WIDTH-1) : sh_q));
			OP_ROL, OP_ROR: res_d = res_q;
			OP_ADD: begin
				if (a_q[WIDTH-1] == b_q[WIDTH-1] && sum[WIDTH-1] != a_q[WIDTH-1])
					st_d = ST_OVF;
				else
					res_d = sum[WIDTH-1:0];
			end
			OP_SUB: begin
				if (a_q[WIDTH-1] != b_q[WIDTH-1] && dif[WIDTH-1] != a_q[WIDTH-1])
					st_d = ST_OVF;
				else
					res_d = dif[WIDTH-1:0];
			end
			OP_NEG: res_d = -a_q;
			OP_MUL: begin
				if (it_hi != '0 || (sn_q ? (it_lo > min_v) : it_lo[WIDTH-1]))
					st_d = ST_OVF;
				else
					res_d = qn;
			end
			OP_DIV: begin
				if (b_q == '0) st_d = ST_DIV0;
				else if (a_q == min_v && b_q == '1) st_d = ST_OVF;
				else res_d = qn;
			end
			OP_EQ: cmp_d = (a_q == b_q);
			OP_NE: cmp_d = (a_q != b_q);
			OP_LT: cmp_d = lt;
			OP_GT: cmp_d = !lt && (a_q != b_q);
			OP_LE: cmp_d = lt || (a_q == b_q);
			OP_GE: cmp_d = !lt;
			default: ;
		endcase
	end

	logic [SH_W-1:0]  rot_m, rot_n;
	logic [2*WIDTH-1:0] rot_w;
	always_comb begin
		rot_m = (sh_q >= WIDTH) ? SH_W'(sh_q - WIDTH) : sh_q;
		if (op_q == OP_ROR) begin
			rot_n = (rot_m == '0) ? '0 : SH_W'(WIDTH - rot_m);
		end else begin
			rot_n = rot_m;
		end
		rot_w = {a_q, a_q} << rot_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			first_q <= 1'b0;
		end else begin
			state_q <= state_d;
			first_q <= (state_q == S_IDLE) && s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			op_q <= s_tdata[OP_W-1:0];
			a_q <= a_w;
			b_q <= b_w;
			sh_q <= s_tdata[OP_W+4*HALF_W +: SH_W];
			sn_q <= a_w[WIDTH-1] ^ b_w[WIDTH-1];
		end
		if (state_q == S_ITER) res_q <= rot_w[2*WIDTH-1 -: WIDTH];
		if (state_q == S_FIX) begin
			res_q <= res_d;
			cmp_q <= cmp_d;
			st_q <= st_d;
		end
	end

	logic [CNT-1:0] res_x;
	assign res_x = CNT'(res_q);
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata = {{(OUT_BYTES_W-CNT-3){1'b0}}, st_q, cmp_q,
		res_x[HALF_W-1:0], res_x[CNT-1:HALF_W]};

`ifndef NO_ASSERTIONS
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("both sides open");
	a_iter_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ictl.busy |-> state_q == S_ITER) else $error("unit busy outside iterate");
	a_cmp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && cmp_q |-> st_q == ST_OK) else $error("compare with error");
`endif

endmodule
